// ===== design/hsi_pkg.sv =====
package hsi_pkg;

  // Fraction bits of the interpolation factor and of the time base.
  localparam int TF = 24;

  localparam int TICK_W = 24;
  localparam int TIME_W = 48;
  localparam int VAL_W  = 32;

  localparam int IN_DATA_W  = 288;
  localparam int OUT_DATA_W = 96;

  localparam logic [TICK_W-1:0] TICK_PERIOD_RST = 24'd279620;

  // The factor t is unsigned Q1.24; one is exactly 2^24.
  localparam logic [TF:0] ONE_T = 25'h100_0000;

  // Largest magnitude a tangent term may take, in Q.40.
  localparam logic [60:0] TANGENT_CAP = 61'h1000_0000_0000_0000;

  // Number of restoring divider stages, one quotient bit each.
  localparam int DIV_STAGES = TF;

  typedef struct packed {
    logic [VAL_W-1:0] p0;
    logic [VAL_W-1:0] p1;
    logic [VAL_W-1:0] v0;
    logic [VAL_W-1:0] v1;
    logic [VAL_W-1:0] s0;
    logic [VAL_W-1:0] s1;
  } payload_t;

  typedef struct packed {
    logic [TIME_W-1:0] rem;
    logic [TIME_W-1:0] den;
    logic [TF-1:0]     quo;
    logic              force_one;
    logic              force_zero;
    logic              dneg;
    payload_t          pl;
  } div_stage_t;

  // Saturates a signed value to 32 bits.
  function automatic logic [VAL_W-1:0] sat32(input logic signed [40:0] x);
    logic [VAL_W-1:0] res;
    if (x > 41'sd2147483647) begin
      res = 32'h7FFF_FFFF;
    end else if (x < -41'sd2147483648) begin
      res = 32'h8000_0000;
    end else begin
      res = x[VAL_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== design/hermite_snapshot_interpolator.sv =====
// Throughput: one item per cycle when the output does not stall; the 24-stage restoring
// divider for the factor and the split 59x54 tangent multiplies are fully pipelined, one stage each step.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and sets tick_period to 279620.
module hermite_snapshot_interpolator (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata, low to high: first_tick[24], second_tick[24], render_time[48],
  // old_position[32], new_position[32], old_velocity[32], new_velocity[32],
  // old_scale[32], new_scale[32]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [hsi_pkg::IN_DATA_W-1:0]      in_tdata,
  // out_tdata, low to high: interp_position[32], interp_velocity[32],
  // interp_scale[32]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [hsi_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                               cfg_wr_en,
  input  logic [hsi_pkg::TICK_W-1:0]         cfg_wr_data
);
  import hsi_pkg::*;

  // Stage map of the valid bits: A, B, 24 divider steps, then C through L.
  localparam int NST   = DIV_STAGES + 12;
  localparam int IDX_C = DIV_STAGES + 2;
  localparam int IDX_J = DIV_STAGES + 9;

  logic en;
  logic in_accept;
  logic [NST-1:0] vld_r;
  logic [TICK_W-1:0] tick_period_r;

  // Stage A: snapshot times.
  logic [TIME_W-1:0] a_t1_r, a_t2_r, a_rt_r;
  payload_t          a_pl_r;

  // Stage B and divider.
  logic signed [TIME_W:0]   b_delta, b_ndelta, b_num;
  logic signed [TIME_W+1:0] b_num_e, b_numn;
  logic                     b_dneg;
  logic [TIME_W-1:0]        b_den;
  div_stage_t               b_nxt;
  div_stage_t               dv_r [0:DIV_STAGES];

  // Stage C: factor.
  logic [TF:0]        c_t_r;
  logic [TIME_W-1:0]  c_dmag_r;
  logic               c_dneg_r;
  payload_t           c_pl_r;

  // Stage D.
  logic [TF:0]               d_omt;
  logic [2*TF+1:0]           d_tsq_r;
  logic [TF:0]               d_t_r;
  logic signed [57:0]        d_mv0_r, d_mv1_r, d_ms0_r, d_ms1_r;
  logic [53:0]               d_d60_r;
  logic                      d_dneg_r;
  logic [VAL_W-1:0]          d_p0_r, d_p1_r, d_v0_r, d_v1_r;

  // Stage E.
  logic [TF:0]               e_t2;
  logic [2*TF+1:0]           e_tcu_r;
  logic [TF:0]               e_t_r, e_t2_r;
  logic signed [58:0]        e_mv_r, e_ms_r;
  logic [53:0]               e_d60_r;
  logic                      e_dneg_r;
  logic [VAL_W-1:0]          e_p0_r, e_p1_r, e_v0_r, e_v1_r;

  // Stage F: Hermite weights and finished mixes.
  logic signed [27:0]        f_t, f_t2, f_t3;
  logic signed [58:0]        f_mv_sh, f_ms_sh;
  logic signed [27:0]        f_h00_r, f_h10_r, f_h01_r, f_h11_r;
  logic [VAL_W-1:0]          f_vel_r, f_scl_r;
  logic [53:0]               f_d60_r;
  logic                      f_dneg_r;
  logic [VAL_W-1:0]          f_p0_r, f_p1_r, f_v0_r, f_v1_r;

  // Stage G: position products and h*v magnitudes.
  logic signed [27:0]        g_nh10, g_nh11;
  logic [26:0]               g_hm0, g_hm1;
  logic signed [VAL_W-1:0]   g_nv0, g_nv1;
  logic [VAL_W-1:0]          g_vm0, g_vm1;
  logic signed [59:0]        g_pp0_r, g_pp1_r;
  logic [58:0]               g_hv0_r, g_hv1_r;
  logic                      g_neg0_r, g_neg1_r;
  logic [53:0]               g_d60_r;
  logic [VAL_W-1:0]          g_vel_r, g_scl_r;

  // Stage H: tangent partial products.
  logic [56:0]               h_ll0_r, h_lh0_r, h_hl0_r, h_hh0_r;
  logic [56:0]               h_ll1_r, h_lh1_r, h_hl1_r, h_hh1_r;
  logic signed [60:0]        h_pps_r;
  logic                      h_neg0_r, h_neg1_r;
  logic [VAL_W-1:0]          h_vel_r, h_scl_r;

  // Stage I: full tangent products.
  logic [112:0]              i_full0_r, i_full1_r;
  logic signed [60:0]        i_pps_r;
  logic                      i_neg0_r, i_neg1_r;
  logic [VAL_W-1:0]          i_vel_r, i_scl_r;

  // Stage J: capped, signed tangent terms.
  logic [88:0]               j_mag0, j_mag1;
  logic [60:0]               j_cm0, j_cm1;
  logic signed [61:0]        j_tan0_r, j_tan1_r;
  logic signed [60:0]        j_pps_r;
  logic [VAL_W-1:0]          j_vel_r, j_scl_r;

  // Stage K: position sum.
  logic signed [63:0]        k_sum_r;
  logic signed [63:0]        k_sum_sh;
  logic [VAL_W-1:0]          k_vel_r, k_scl_r;

  // Stage L: output register.
  logic [VAL_W-1:0]          l_pos_r, l_vel_r, l_scl_r;

  // The pipeline moves as a whole whenever the output register can take a result.
  assign en        = !vld_r[NST-1] || out_tready;
  assign in_tready = en;
  assign in_accept = in_tvalid && in_tready;

  assign out_tvalid = vld_r[NST-1];
  assign out_tdata  = {l_scl_r, l_vel_r, l_pos_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_period_r <= TICK_PERIOD_RST;
    end else if (cfg_wr_en) begin
      tick_period_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_accept};
    end
  end

  // Stage A: tick numbers become Q24.24 times.
  always_ff @(posedge clk) begin
    if (en) begin
      a_t1_r    <= in_tdata[23:0] * tick_period_r;
      a_t2_r    <= in_tdata[47:24] * tick_period_r;
      a_rt_r    <= in_tdata[95:48];
      a_pl_r.p0 <= in_tdata[127:96];
      a_pl_r.p1 <= in_tdata[159:128];
      a_pl_r.v0 <= in_tdata[191:160];
      a_pl_r.v1 <= in_tdata[223:192];
      a_pl_r.s0 <= in_tdata[255:224];
      a_pl_r.s1 <= in_tdata[287:256];
    end
  end

  // Stage B: the numerator and denominator are made positive, and the cases that
  // need no division (equal times, render time outside the interval) are flagged.
  always_comb begin
    b_delta  = $signed({1'b0, a_t2_r}) - $signed({1'b0, a_t1_r});
    b_ndelta = -b_delta;
    b_num    = $signed({1'b0, a_rt_r}) - $signed({1'b0, a_t1_r});
    b_dneg   = b_delta[TIME_W];
    b_den    = b_dneg ? b_ndelta[TIME_W-1:0] : b_delta[TIME_W-1:0];
    b_num_e  = {b_num[TIME_W], b_num};
    b_numn   = b_dneg ? -b_num_e : b_num_e;
    b_nxt.rem        = b_numn[TIME_W-1:0];
    b_nxt.den        = b_den;
    b_nxt.quo        = '0;
    b_nxt.dneg       = b_dneg;
    b_nxt.pl         = a_pl_r;
    b_nxt.force_one  = 1'b0;
    b_nxt.force_zero = 1'b0;
    priority if (b_den == '0) begin
      b_nxt.force_one = 1'b1;
    end else if (b_numn[TIME_W+1] || (b_numn == '0)) begin
      b_nxt.force_zero = 1'b1;
    end else if (b_numn[TIME_W:0] >= {1'b0, b_den}) begin
      b_nxt.force_one = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= b_nxt;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    logic [TIME_W:0] r2;
    logic            ge;
    div_stage_t      nxt;
    always_comb begin
      r2      = {dv_r[g].rem, 1'b0};
      ge      = r2 >= {1'b0, dv_r[g].den};
      nxt     = dv_r[g];
      nxt.rem = ge ? TIME_W'(r2 - {1'b0, dv_r[g].den}) : r2[TIME_W-1:0];
      nxt.quo = {dv_r[g].quo[TF-2:0], ge};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[g+1] <= nxt;
      end
    end
  end

  // Stage C: select the factor.
  always_ff @(posedge clk) begin
    if (en) begin
      priority if (dv_r[DIV_STAGES].force_one) begin
        c_t_r <= ONE_T;
      end else if (dv_r[DIV_STAGES].force_zero) begin
        c_t_r <= '0;
      end else begin
        c_t_r <= {1'b0, dv_r[DIV_STAGES].quo};
      end
      c_dmag_r <= dv_r[DIV_STAGES].den;
      c_dneg_r <= dv_r[DIV_STAGES].dneg;
      c_pl_r   <= dv_r[DIV_STAGES].pl;
    end
  end

  // Stage D: t squared, the mix products and 60 * |delta|.
  assign d_omt = ONE_T - c_t_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d_tsq_r  <= c_t_r * c_t_r;
      d_t_r    <= c_t_r;
      d_mv0_r  <= $signed(c_pl_r.v0) * $signed({1'b0, d_omt});
      d_mv1_r  <= $signed(c_pl_r.v1) * $signed({1'b0, c_t_r});
      d_ms0_r  <= $signed(c_pl_r.s0) * $signed({1'b0, d_omt});
      d_ms1_r  <= $signed(c_pl_r.s1) * $signed({1'b0, c_t_r});
      d_d60_r  <= (54'(c_dmag_r) << 6) - (54'(c_dmag_r) << 2);
      d_dneg_r <= c_dneg_r;
      d_p0_r   <= c_pl_r.p0;
      d_p1_r   <= c_pl_r.p1;
      d_v0_r   <= c_pl_r.v0;
      d_v1_r   <= c_pl_r.v1;
    end
  end

  // Stage E: t cubed and the mix sums.
  assign e_t2 = d_tsq_r[2*TF:TF];

  always_ff @(posedge clk) begin
    if (en) begin
      e_tcu_r  <= e_t2 * d_t_r;
      e_t_r    <= d_t_r;
      e_t2_r   <= e_t2;
      e_mv_r   <= 59'(d_mv0_r) + 59'(d_mv1_r);
      e_ms_r   <= 59'(d_ms0_r) + 59'(d_ms1_r);
      e_d60_r  <= d_d60_r;
      e_dneg_r <= d_dneg_r;
      e_p0_r   <= d_p0_r;
      e_p1_r   <= d_p1_r;
      e_v0_r   <= d_v0_r;
      e_v1_r   <= d_v1_r;
    end
  end

  // Stage F: Hermite basis weights, signed Q.24.
  assign f_t     = $signed({3'b0, e_t_r});
  assign f_t2    = $signed({3'b0, e_t2_r});
  assign f_t3    = $signed({3'b0, e_tcu_r[2*TF:TF]});
  assign f_mv_sh = e_mv_r >>> TF;
  assign f_ms_sh = e_ms_r >>> TF;

  always_ff @(posedge clk) begin
    if (en) begin
      f_h00_r  <= 28'(2 * f_t3 - 3 * f_t2 + $signed({3'b0, ONE_T}));
      f_h10_r  <= 28'(f_t3 - 2 * f_t2 + f_t);
      f_h01_r  <= 28'(3 * f_t2 - 2 * f_t3);
      f_h11_r  <= 28'(f_t3 - f_t2);
      f_vel_r  <= sat32(f_mv_sh[40:0]);
      f_scl_r  <= sat32(f_ms_sh[40:0]);
      f_d60_r  <= e_d60_r;
      f_dneg_r <= e_dneg_r;
      f_p0_r   <= e_p0_r;
      f_p1_r   <= e_p1_r;
      f_v0_r   <= e_v0_r;
      f_v1_r   <= e_v1_r;
    end
  end

  // Stage G: position terms and tangent magnitudes |h| * |v|.
  assign g_nh10 = -f_h10_r;
  assign g_nh11 = -f_h11_r;
  assign g_hm0  = f_h10_r[27] ? g_nh10[26:0] : f_h10_r[26:0];
  assign g_hm1  = f_h11_r[27] ? g_nh11[26:0] : f_h11_r[26:0];
  assign g_nv0  = -$signed(f_v0_r);
  assign g_nv1  = -$signed(f_v1_r);
  assign g_vm0  = f_v0_r[31] ? g_nv0 : f_v0_r;
  assign g_vm1  = f_v1_r[31] ? g_nv1 : f_v1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      g_pp0_r  <= f_h00_r * $signed(f_p0_r);
      g_pp1_r  <= f_h01_r * $signed(f_p1_r);
      g_hv0_r  <= g_hm0 * g_vm0;
      g_hv1_r  <= g_hm1 * g_vm1;
      g_neg0_r <= f_h10_r[27] ^ f_v0_r[31] ^ f_dneg_r;
      g_neg1_r <= f_h11_r[27] ^ f_v1_r[31] ^ f_dneg_r;
      g_d60_r  <= f_d60_r;
      g_vel_r  <= f_vel_r;
      g_scl_r  <= f_scl_r;
    end
  end

  // Stage H: each 59x54 tangent product as four partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      h_ll0_r  <= g_hv0_r[29:0] * g_d60_r[26:0];
      h_lh0_r  <= g_hv0_r[29:0] * g_d60_r[53:27];
      h_hl0_r  <= g_hv0_r[58:30] * g_d60_r[26:0];
      h_hh0_r  <= g_hv0_r[58:30] * g_d60_r[53:27];
      h_ll1_r  <= g_hv1_r[29:0] * g_d60_r[26:0];
      h_lh1_r  <= g_hv1_r[29:0] * g_d60_r[53:27];
      h_hl1_r  <= g_hv1_r[58:30] * g_d60_r[26:0];
      h_hh1_r  <= g_hv1_r[58:30] * g_d60_r[53:27];
      h_pps_r  <= 61'(g_pp0_r) + 61'(g_pp1_r);
      h_neg0_r <= g_neg0_r;
      h_neg1_r <= g_neg1_r;
      h_vel_r  <= g_vel_r;
      h_scl_r  <= g_scl_r;
    end
  end

  // Stage I: partial products recombined. The low-by-high product sits at the
  // split point of the span (bit 27), the high-by-low one at that of h*v (bit 30).
  always_ff @(posedge clk) begin
    if (en) begin
      i_full0_r <= (113'(h_hh0_r) << 57) + (113'(h_lh0_r) << 27) + (113'(h_hl0_r) << 30)
                   + 113'(h_ll0_r);
      i_full1_r <= (113'(h_hh1_r) << 57) + (113'(h_lh1_r) << 27) + (113'(h_hl1_r) << 30)
                   + 113'(h_ll1_r);
      i_pps_r   <= h_pps_r;
      i_neg0_r  <= h_neg0_r;
      i_neg1_r  <= h_neg1_r;
      i_vel_r   <= h_vel_r;
      i_scl_r   <= h_scl_r;
    end
  end

  // Stage J: truncate to Q.40, cap the magnitude and apply the sign.
  assign j_mag0 = i_full0_r[112:TF];
  assign j_mag1 = i_full1_r[112:TF];
  assign j_cm0  = (j_mag0 > 89'(TANGENT_CAP)) ? TANGENT_CAP : j_mag0[60:0];
  assign j_cm1  = (j_mag1 > 89'(TANGENT_CAP)) ? TANGENT_CAP : j_mag1[60:0];

  always_ff @(posedge clk) begin
    if (en) begin
      j_tan0_r <= i_neg0_r ? -$signed({1'b0, j_cm0}) : $signed({1'b0, j_cm0});
      j_tan1_r <= i_neg1_r ? -$signed({1'b0, j_cm1}) : $signed({1'b0, j_cm1});
      j_pps_r  <= i_pps_r;
      j_vel_r  <= i_vel_r;
      j_scl_r  <= i_scl_r;
    end
  end

  // Stage K: sum of the four Hermite terms.
  always_ff @(posedge clk) begin
    if (en) begin
      k_sum_r <= 64'(j_pps_r) + 64'(j_tan0_r) + 64'(j_tan1_r);
      k_vel_r <= j_vel_r;
      k_scl_r <= j_scl_r;
    end
  end

  // Stage L: floor to Q16.16, saturate, and hold for the output transfer.
  assign k_sum_sh = k_sum_r >>> TF;

  always_ff @(posedge clk) begin
    if (en) begin
      l_pos_r <= sat32(k_sum_sh[40:0]);
      l_vel_r <= k_vel_r;
      l_scl_r <= k_scl_r;
    end
  end

  // Reset leaves no result on the output.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // The selected factor never exceeds one.
  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[IDX_C] |-> (c_t_r <= ONE_T))
    else $error("interpolation factor out of range");

  // A stall freezes the occupancy of every stage.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved during stall");

  // The first tangent term (j_tan0_r) stays within the cap.
  a_tan_cap: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[IDX_J] |-> ((j_tan0_r <= $signed({1'b0, TANGENT_CAP}))
                      && (j_tan0_r >= -$signed({1'b0, TANGENT_CAP}))))
    else $error("tangent term exceeds cap");

endmodule
